// ===== rtl/ole_pkg.sv =====
package ole_pkg;

    localparam int CAPACITY    = 64;
    localparam int SLOT_W      = $clog2(CAPACITY);
    localparam int COUNT_W     = $clog2(CAPACITY + 1);
    localparam int VALUE_W     = 32;

    // Request codes.
    localparam logic [2:0] ACT_INS_HEAD = 3'd0;
    localparam logic [2:0] ACT_INS_TAIL = 3'd1;
    localparam logic [2:0] ACT_INS_AT   = 3'd2;
    localparam logic [2:0] ACT_DEL_HEAD = 3'd3;
    localparam logic [2:0] ACT_DEL_TAIL = 3'd4;
    localparam logic [2:0] ACT_DEL_VAL  = 3'd5;
    localparam logic [2:0] ACT_SEARCH   = 3'd6;
    localparam logic [2:0] ACT_CLEAR    = 3'd7;

    // Status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_POS   = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    // One node as held in the store.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [SLOT_W-1:0]  next;
        logic [SLOT_W-1:0]  prev;
    } t_node;

    // Write request from the controller to the store.
    typedef struct packed {
        logic               we;
        logic [SLOT_W-1:0]  addr;
        t_node              data;
    } t_node_wr;

endpackage

// ===== rtl/ordered_list_engine_core.sv =====
// Ordered list engine: a bounded doubly linked list of signed 32-bit values.
// Requests enter on the s_axis channel (tdata: item_value, item_position;
// tuser: action). Each request yields exactly one result on the m_axis
// channel (tdata: result_value, result_position, entry_total; tuser: status).
// The block handles one request at a time. Clear and requests that are turned
// away with an error status go straight to the output state. Head and tail
// inserts and deletes need no walk. Insert at a position, delete by value and
// search walk the node memory one link per cycle, since each step needs the
// next link read from the single read port. The next request is accepted at
// the earliest in the cycle after the result transfer. The result sits in an
// output register; a new request is taken only after that result has been
// transferred. When the receiver stalls, the result holds and input ready
// stays low.
// Reset clears the count, the head and tail pointers and the slot map; the
// node memory needs no initialization since only linked slots are read.
module ordered_list_engine_core
    import ole_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // item_value[31:0], item_position[38:32], zero
    input  logic [2:0]  s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // result_value[31:0], result_position[37:32],
                                        // entry_total[44:38], zero
    output logic [2:0]  m_axis_tuser    // status
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WALK  = 3'd1;
    localparam logic [2:0] S_FIX1  = 3'd2;
    localparam logic [2:0] S_FIX2  = 3'd3;
    localparam logic [2:0] S_FIX3  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;
    localparam logic [2:0] S_RD    = 3'd6;

    logic [2:0]          r_state, n_state;
    logic [2:0]          r_act, n_act;
    logic [VALUE_W-1:0]  r_val, n_val;
    logic [6:0]          r_pos, n_pos;
    logic [SLOT_W-1:0]   r_first, n_first;
    logic [SLOT_W-1:0]   r_last, n_last;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [SLOT_W-1:0]   r_cur, n_cur;
    logic [COUNT_W-1:0]  r_idx, n_idx;
    logic [SLOT_W-1:0]   r_ns, n_ns;
    logic [SLOT_W-1:0]   r_p, n_p;
    logic [SLOT_W-1:0]   r_n, n_n;
    logic [VALUE_W-1:0]  r_rm, n_rm;
    logic                r_ovalid, n_ovalid;
    logic [2:0]          r_ost, n_ost;
    logic [VALUE_W-1:0]  r_oval, n_oval;
    logic [SLOT_W-1:0]   r_opos, n_opos;

    t_node_wr            wr;
    logic [SLOT_W-1:0]   raddr;
    t_node               rdata;
    logic                take, rel, clr;
    logic [SLOT_W-1:0]   rel_slot, free_slot;
    logic                in_fire;

    ole_node_ram u_ram (
        .i_clk   (i_clk),
        .i_wr    (wr),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    ole_free_map u_free (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (take),
        .i_release      (rel),
        .i_release_slot (rel_slot),
        .i_clear        (clr),
        .o_free_slot    (free_slot)
    );

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_ost;
    assign m_axis_tdata  = {3'b000, 7'(r_count), r_opos, r_oval};

    // Main sequencer: read a node, decide, write links back.
    always_comb begin
        n_state = r_state; n_act = r_act; n_val = r_val; n_pos = r_pos;
        n_first = r_first; n_last = r_last; n_count = r_count;
        n_cur = r_cur; n_idx = r_idx; n_ns = r_ns; n_p = r_p; n_n = r_n;
        n_rm = r_rm; n_ovalid = r_ovalid; n_ost = r_ost; n_oval = r_oval;
        n_opos = r_opos;
        wr = '0; raddr = r_cur; take = 1'b0; rel = 1'b0; rel_slot = r_cur;
        clr = 1'b0;
        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_act = s_axis_tuser;
                    n_val = s_axis_tdata[31:0];
                    n_pos = s_axis_tdata[38:32];
                    n_ost = ST_OK; n_oval = s_axis_tdata[31:0]; n_opos = '0;
                    n_cur = r_first; n_idx = '0;
                    n_state = S_OUT;
                    case (s_axis_tuser) inside
                        ACT_INS_HEAD, ACT_INS_TAIL, ACT_INS_AT: begin
                            if (s_axis_tuser == ACT_INS_AT &&
                                COUNT_W'(s_axis_tdata[38:32]) > r_count) begin
                                n_ost = ST_BAD_POS;
                            end else if (s_axis_tuser == ACT_INS_AT &&
                                         s_axis_tdata[38:32] > 7'(CAPACITY)) begin
                                n_ost = ST_BAD_POS;
                            end else if (r_count == COUNT_W'(CAPACITY)) begin
                                n_ost = ST_FULL;
                            end else begin
                                n_ns = free_slot;
                                take = 1'b1;
                                if (s_axis_tuser == ACT_INS_HEAD ||
                                    (s_axis_tuser == ACT_INS_AT &&
                                     s_axis_tdata[38:32] == 7'd0)) begin
                                    n_act = ACT_INS_HEAD;
                                    n_state = S_FIX1;
                                end else if (s_axis_tuser == ACT_INS_TAIL ||
                                    COUNT_W'(s_axis_tdata[38:32]) == r_count) begin
                                    n_act = ACT_INS_TAIL;
                                    n_state = S_FIX1;
                                end else begin
                                    raddr = r_first;
                                    n_state = S_WALK;
                                end
                            end
                        end
                        ACT_DEL_HEAD, ACT_DEL_TAIL, ACT_DEL_VAL, ACT_SEARCH: begin
                            if (s_axis_tuser != ACT_DEL_VAL &&
                                s_axis_tuser != ACT_SEARCH) begin
                                n_oval = '0;
                            end
                            if (r_count == '0) begin
                                n_ost = ST_EMPTY;
                            end else begin
                                n_cur = (s_axis_tuser == ACT_DEL_TAIL) ? r_last : r_first;
                                raddr = n_cur;
                                n_state = (s_axis_tuser == ACT_DEL_HEAD ||
                                           s_axis_tuser == ACT_DEL_TAIL) ? S_RD : S_WALK;
                            end
                        end
                        default: begin
                            clr = 1'b1;
                            n_first = '0; n_last = '0; n_count = '0;
                            n_oval = '0;
                        end
                    endcase
                end
            end
            S_WALK: begin
                // rdata holds node r_cur, at list index r_idx.
                if (r_act == ACT_INS_AT) begin
                    if (7'(r_idx) == r_pos) begin
                        n_p = rdata.prev;
                        n_state = S_FIX1;
                    end else begin
                        n_cur = rdata.next;
                        raddr = rdata.next;
                        n_idx = r_idx + 1'b1;
                    end
                end else if (rdata.value == r_val) begin
                    // Only a search reports the position of the match.
                    if (r_act == ACT_SEARCH) begin
                        n_opos = SLOT_W'(r_idx);
                        n_state = S_OUT;
                    end else begin
                        n_p = rdata.prev; n_n = rdata.next; n_rm = rdata.value;
                        n_state = S_FIX2;
                    end
                end else if (r_idx + 1'b1 == r_count) begin
                    n_ost = ST_NOT_FOUND;
                    n_state = S_OUT;
                end else begin
                    n_cur = rdata.next;
                    raddr = rdata.next;
                    n_idx = r_idx + 1'b1;
                end
            end
            S_RD: begin
                n_p = rdata.prev; n_n = rdata.next; n_rm = rdata.value;
                n_state = S_FIX2;
            end
            S_FIX1: begin
                // Write the new node, then patch the neighbor(s).
                wr.we = 1'b1; wr.addr = r_ns; wr.data.value = r_val;
                n_count = r_count + 1'b1;
                n_state = S_OUT;
                if (r_act == ACT_INS_HEAD) begin
                    wr.data.next = r_first; wr.data.prev = '0;
                    if (r_count == '0) begin
                        n_last = r_ns;
                    end else begin
                        raddr = r_first; n_cur = r_first; n_state = S_FIX3;
                    end
                    n_first = r_ns;
                end else if (r_act == ACT_INS_TAIL) begin
                    wr.data.next = '0; wr.data.prev = r_last;
                    if (r_count == '0) begin
                        n_first = r_ns;
                    end else begin
                        raddr = r_last; n_cur = r_last; n_state = S_FIX3;
                    end
                    n_last = r_ns;
                end else begin
                    wr.data.next = r_cur; wr.data.prev = r_p;
                    raddr = r_p; n_state = S_FIX3;
                end
            end
            S_FIX3: begin
                // rdata is the neighbor read last cycle; patch its link.
                wr.we = 1'b1; wr.data = rdata;
                if (r_act == ACT_INS_HEAD) begin
                    wr.addr = r_cur; wr.data.prev = r_ns;
                    n_state = S_OUT;
                end else if (r_act == ACT_INS_TAIL) begin
                    wr.addr = r_cur; wr.data.next = r_ns;
                    n_state = S_OUT;
                end else begin
                    wr.addr = r_p; wr.data.next = r_ns;
                    raddr = r_cur; n_act = ACT_INS_TAIL; n_state = S_FIX3;
                    // Next pass patches prev of cur to the new node.
                    n_act = ACT_INS_HEAD;
                end
            end
            S_FIX2: begin
                // Unlink r_cur; a middle node has its neighbors patched in two read-modify-writes.
                rel = 1'b1; rel_slot = r_cur;
                n_oval = r_rm;
                n_count = r_count - 1'b1;
                n_state = S_OUT;
                if (r_count == COUNT_W'(1)) begin
                    n_first = '0; n_last = '0;
                end else if (r_cur == r_first) begin
                    n_first = r_n;
                end else if (r_cur == r_last) begin
                    n_last = r_p;
                end else begin
                    raddr = r_p; n_state = S_FIX3; n_act = ACT_DEL_VAL;
                end
                if (r_act == ACT_DEL_VAL && n_state == S_FIX3) begin
                    n_act = ACT_SEARCH;
                end
            end
            default: begin
                n_ovalid = 1'b1;
                n_state = S_IDLE;
            end
        endcase
        // Middle unlink: two extra patch steps handled here.
        if (r_state == S_FIX3 && r_act == ACT_SEARCH) begin
            wr.we = 1'b1; wr.data = rdata; wr.addr = r_p; wr.data.next = r_n;
            raddr = r_n; n_act = ACT_DEL_HEAD; n_state = S_FIX3;
        end else if (r_state == S_FIX3 && r_act == ACT_DEL_HEAD) begin
            wr.we = 1'b1; wr.data = rdata; wr.addr = r_n; wr.data.prev = r_p;
            n_state = S_OUT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_first <= '0;
            r_last  <= '0;
            r_count <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_first <= n_first;
            r_last  <= n_last;
            r_count <= n_count;
            r_ovalid <= n_ovalid;
        end
        r_act <= n_act; r_val <= n_val; r_pos <= n_pos; r_cur <= n_cur;
        r_idx <= n_idx; r_ns <= n_ns; r_p <= n_p; r_n <= n_n; r_rm <= n_rm;
        r_ost <= n_ost; r_oval <= n_oval; r_opos <= n_opos;
    end

endmodule

// ===== rtl/ole_node_ram.sv =====
module ole_node_ram
    import ole_pkg::*;
(
    input  logic              i_clk,
    input  t_node_wr          i_wr,
    input  logic [SLOT_W-1:0] i_raddr,
    output t_node             o_rdata
);

    t_node r_mem [CAPACITY];

    // Single write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/ole_free_map.sv =====
module ole_free_map
    import ole_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic              i_release,
    input  logic [SLOT_W-1:0] i_release_slot,
    input  logic              i_clear,
    output logic [SLOT_W-1:0] o_free_slot
);

    logic [CAPACITY-1:0] r_used;
    logic [CAPACITY-1:0] n_used;

    // Lowest free slot, found by a priority search over the in-use bits.
    always_comb begin
        o_free_slot = '0;
        for (int k = CAPACITY - 1; k >= 0; k--) begin
            if (!r_used[k]) begin
                o_free_slot = SLOT_W'(k);
            end
        end
    end

    always_comb begin
        n_used = r_used;
        if (i_clear) begin
            n_used = '0;
        end else begin
            if (i_take) begin
                n_used[o_free_slot] = 1'b1;
            end
            if (i_release) begin
                n_used[i_release_slot] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            r_used <= n_used;
        end
    end

endmodule

// ===== tb/tb.sv =====
module tb;
    import ole_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TOTAL  = 450;
    localparam int STALL_LIMIT = 6000;
    localparam int DRAIN_WAIT  = 80;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value;
        logic [5:0]  position;
        logic [6:0]  total;
    } list_result_t;

    typedef struct {
        logic [2:0]   action;
        logic [31:0]  value;
        logic [6:0]   position;
        bit           typed;
        list_result_t result;
    } request_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;    // item_value, item_position, zero
    logic [2:0]  s_axis_tuser;    // action
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;    // result_value, result_position, entry_total, zero
    logic [2:0]  m_axis_tuser;    // status

    // Predicted list contents, head first.
    logic [31:0]  list_values[$];
    list_result_t pending_results[$];
    request_row_t directed_rows[$];

    int mismatch_count;
    int idle_pct;
    int stall_pct;
    int quiet_cycles;

    ordered_list_engine_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock with a 12 ns period.
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Applies one request to the predicted list and returns its result.
    function automatic list_result_t apply_request(logic [2:0] act, logic [31:0] val,
                                                   logic [6:0] pos);
        list_result_t r;
        int           hit;
        r = '{status: ST_OK, value: 32'd0, position: 6'd0, total: 7'd0};
        hit = -1;
        if (act == ACT_DEL_VAL || act == ACT_SEARCH) begin
            for (int i = 0; i < list_values.size(); i++) begin
                if (hit < 0 && list_values[i] == val) hit = i;
            end
        end
        case (act) inside
            ACT_INS_HEAD, ACT_INS_TAIL: begin
                r.value = val;
                if (list_values.size() >= CAPACITY) r.status = ST_FULL;
                else if (act == ACT_INS_HEAD) list_values.push_front(val);
                else list_values.push_back(val);
            end
            ACT_INS_AT: begin
                r.value = val;
                if (pos > list_values.size()) r.status = ST_BAD_POS;
                else if (list_values.size() >= CAPACITY) r.status = ST_FULL;
                else list_values.insert(pos, val);
            end
            ACT_DEL_HEAD, ACT_DEL_TAIL: begin
                if (list_values.size() == 0) r.status = ST_EMPTY;
                else if (act == ACT_DEL_HEAD) r.value = list_values.pop_front();
                else r.value = list_values.pop_back();
            end
            ACT_DEL_VAL, ACT_SEARCH: begin
                r.value = val;
                if (list_values.size() == 0) begin
                    r.status = ST_EMPTY;
                end else if (hit < 0) begin
                    r.status = ST_NOT_FOUND;
                end else if (act == ACT_SEARCH) begin
                    r.position = hit[5:0];
                end else begin
                    r.value = list_values[hit];
                    list_values.delete(hit);
                end
            end
            default: list_values.delete();
        endcase
        r.total = 7'(list_values.size());
        return r;
    endfunction

    // Offers one request, waits for its transfer and records the expected result.
    task automatic send_request(request_row_t row);
        list_result_t predicted;
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = row.action;
        s_axis_tdata  = {1'b0, row.position, row.value};
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = apply_request(row.action, row.value, row.position);
        pending_results.push_back(row.typed ? row.result : predicted);
        @(negedge i_clk);
    endtask

    function automatic void add_row(logic [2:0] act, logic [31:0] val, logic [6:0] pos,
                                    bit typed = 0, logic [2:0] st = ST_OK,
                                    logic [31:0] rv = 0, logic [6:0] tot = 0);
        directed_rows.push_back('{act, val, pos, typed, '{st, rv, 6'd0, tot}});
    endfunction

    function automatic logic [31:0] pick_value();
        logic [31:0] pool[8] = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                 32'd1, 32'd2, 32'd3, 32'h5555_AAAA};
        if ($urandom_range(99) < 70) return pool[$urandom_range(7)];
        return $urandom;
    endfunction

    // Builds a random request; mode 0 biases toward filling the list, mode 1 toward draining it.
    function automatic request_row_t random_row(int mode);
        request_row_t row;
        int           roll;
        roll = $urandom_range(99);
        row.typed = 0;
        row.result = '{ST_OK, 32'd0, 6'd0, 7'd0};
        row.value = pick_value();
        if (roll < 2)
            row.action = ACT_CLEAR;
        else if (mode == 0 && roll < 85)
            row.action = 3'($urandom_range(ACT_INS_AT, ACT_INS_HEAD));
        else if (mode == 1 && roll < 60)
            row.action = 3'($urandom_range(ACT_DEL_VAL, ACT_DEL_HEAD));
        else
            row.action = 3'($urandom_range(ACT_SEARCH, ACT_INS_HEAD));
        if ($urandom_range(99) < 80)
            row.position = 7'($urandom_range(list_values.size(), 0));
        else
            row.position = 7'($urandom_range(CAPACITY, 0));
        return row;
    endfunction

    // Receiver readiness changes at the falling edge.
    always @(negedge i_clk) begin
        m_axis_tready = ($urandom_range(99) >= stall_pct);
    end

    // Result checker.
    always @(posedge i_clk) begin
        list_result_t got;
        list_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[37:32],
                    m_axis_tdata[44:38]};
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result: status %0d value %h", got.status, got.value);
            end else begin
                want = pending_results.pop_front();
                if (got != want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $write("Mismatch: expected st %0d val %h pos %0d tot %0d, ",
                               want.status, want.value, want.position, want.total);
                        $display("got st %0d val %h pos %0d tot %0d",
                                 got.status, got.value, got.position, got.total);
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either side.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int phase_pct[4][2];
        phase_pct      = '{'{0, 0}, '{83, 0}, '{0, 83}, '{37, 37}};
        mismatch_count = 0;
        quiet_cycles   = 0;
        idle_pct       = 0;
        stall_pct      = 0;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = ACT_INS_HEAD;
        m_axis_tready  = 1'b1;

        // Empty list, bad positions, extremes, matches and misses, clear.
        add_row(ACT_SEARCH,   32'd5,         7'd0,  1, ST_EMPTY,     32'd5,         7'd0);
        add_row(ACT_DEL_HEAD, 32'd9,         7'd0,  1, ST_EMPTY,     32'd0,         7'd0);
        add_row(ACT_DEL_TAIL, 32'd9,         7'd0,  1, ST_EMPTY,     32'd0,         7'd0);
        add_row(ACT_DEL_VAL,  32'd7,         7'd0,  1, ST_EMPTY,     32'd7,         7'd0);
        add_row(ACT_INS_AT,   32'd9,         7'd1,  1, ST_BAD_POS,   32'd9,         7'd0);
        add_row(ACT_INS_HEAD, 32'h7FFF_FFFF, 7'd0,  1, ST_OK,        32'h7FFF_FFFF, 7'd1);
        add_row(ACT_INS_TAIL, 32'h8000_0000, 7'd0,  1, ST_OK,        32'h8000_0000, 7'd2);
        add_row(ACT_INS_AT,   32'hFFFF_FFFF, 7'd0,  1, ST_OK,        32'hFFFF_FFFF, 7'd3);
        add_row(ACT_INS_AT,   32'd0,         7'd3,  1, ST_OK,        32'd0,         7'd4);
        add_row(ACT_INS_AT,   32'h55AA_55AA, 7'd2);
        add_row(ACT_INS_AT,   32'd1,         7'd64, 1, ST_BAD_POS,   32'd1,         7'd5);
        add_row(ACT_SEARCH,   32'h8000_0000, 7'd0);
        add_row(ACT_SEARCH,   32'h0001_2345, 7'd0,  1, ST_NOT_FOUND, 32'h0001_2345, 7'd5);
        add_row(ACT_DEL_VAL,  32'h0001_2345, 7'd0,  1, ST_NOT_FOUND, 32'h0001_2345, 7'd5);
        add_row(ACT_INS_TAIL, 32'hFFFF_FFFF, 7'd0);
        add_row(ACT_SEARCH,   32'hFFFF_FFFF, 7'd0);
        add_row(ACT_DEL_VAL,  32'hFFFF_FFFF, 7'd0);
        add_row(ACT_DEL_VAL,  32'h7FFF_FFFF, 7'd0);
        add_row(ACT_DEL_HEAD, 32'd0,         7'd0);
        add_row(ACT_DEL_TAIL, 32'd0,         7'd0);
        add_row(ACT_CLEAR,    32'hFFFF_FFFF, 7'd127, 1, ST_OK,       32'd0,         7'd0);
        add_row(ACT_CLEAR,    32'd0,         7'd0,  1, ST_OK,        32'd0,         7'd0);

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) send_request(directed_rows[i]);

        // Random part in four pacing phases; the mode shifts every 30 requests.
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = phase_pct[ph][0];
            stall_pct = phase_pct[ph][1];
            for (int n = 0; n < ITEM_TOTAL / 4; n++) begin
                send_request(random_row((n / 30 + ph) % 3));
            end
        end
        s_axis_tvalid = 1'b0;
        stall_pct = 0;

        wait (pending_results.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ole_pkg.sv
rtl/ole_node_ram.sv
rtl/ole_free_map.sv
rtl/ordered_list_engine_core.sv
tb/tb.sv
